// ===== rtl/prgp_pkg.sv =====
// shared widths, register indexes and types for the ground projection block
// no dependencies; compiled first

package prgp_pkg;

  localparam int PIX_W      = 12;
  localparam int FOC_W      = 12;
  localparam int ROT_W      = 16;
  localparam int ROW_W      = 3 * ROT_W;
  localparam int OFS_W      = 16;
  localparam int HGT_W      = 16;
  localparam int GND_W      = 16;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = ROW_W;

  // normalized coordinate: magnitude of pixel times 2^16 over focal length, then signed
  localparam int FRAC_W = 16;
  localparam int NMAG_W = PIX_W + FRAC_W;
  localparam int NRM_W  = NMAG_W + 1;

  // ray components and their magnitudes
  localparam int V_W   = 46;
  localparam int MAG_W = V_W - 1;

  // plane path
  localparam int PQ_W   = 18;
  localparam int PNUM_W = MAG_W + HGT_W;

  // horizon path
  localparam int HS_W   = 31;
  localparam int SQ_W   = 2 * HS_W + 1;
  localparam int RT_W   = 32;
  localparam int HL_W   = 15;
  localparam int HNUM_W = HS_W + HL_W;
  localparam int HQ_W   = HL_W;

  localparam logic [CFG_ADDR_W-1:0] REG_ROT_ROW0 = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_ROT_ROW1 = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_ROT_ROW2 = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_FOCAL_X  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_FOCAL_Y  = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_OFFSET_X = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_OFFSET_Y = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_HEIGHT   = 3'd7;

  typedef struct packed {
    logic signed [V_W-1:0] v0;
    logic signed [V_W-1:0] v1;
    logic signed [V_W-1:0] v2;
  } ray_t;

  typedef struct packed {
    logic [ROW_W-1:0]        rot0;
    logic [ROW_W-1:0]        rot1;
    logic [ROW_W-1:0]        rot2;
    logic [FOC_W-1:0]        foc_x;
    logic [FOC_W-1:0]        foc_y;
    logic signed [OFS_W-1:0] ofs_x;
    logic signed [OFS_W-1:0] ofs_y;
    logic [HGT_W-1:0]        height;
  } cam_cfg_t;

  function automatic logic signed [ROT_W-1:0] rot_elem(input logic [ROW_W-1:0] row,
                                                       input int k);
    return $signed(row[ROT_W*k +: ROT_W]);
  endfunction

endpackage

// ===== rtl/prgp_if.sv =====
// valid/ready channel interfaces for pixel input and ground result
// depends on prgp_pkg

interface prgp_pix_if import prgp_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [PIX_W-1:0] pix_x;
  logic signed [PIX_W-1:0] pix_y;

  modport source (output valid, pix_x, pix_y, input ready);
  modport sink   (input valid, pix_x, pix_y, output ready);
endinterface

interface prgp_gnd_if import prgp_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [GND_W-1:0] ground_x;
  logic signed [GND_W-1:0] ground_y;
  logic                    on_plane;

  modport source (output valid, ground_x, ground_y, on_plane, input ready);
  modport sink   (input valid, ground_x, ground_y, on_plane, output ready);
endinterface

// ===== rtl/prgp_div2.sv =====
// two-lane pipelined restoring divider, one quotient bit per stage
// no package dependency; caller guarantees num < den << Q_W for valid lanes

module prgp_div2 #(
  parameter int NUM_W = 28,
  parameter int DEN_W = 12,
  parameter int Q_W   = 28,
  parameter int TAG_W = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [NUM_W-1:0] num_a,
  input  logic [NUM_W-1:0] num_b,
  input  logic [DEN_W-1:0] den_a,
  input  logic [DEN_W-1:0] den_b,
  input  logic [TAG_W-1:0] tag_in,
  output logic             out_valid,
  output logic [Q_W-1:0]   quot_a,
  output logic [Q_W-1:0]   quot_b,
  output logic [TAG_W-1:0] tag_out
);

  localparam int CMP_W = ((NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W) + 1;

  logic [NUM_W-1:0] rem_a [Q_W];
  logic [NUM_W-1:0] rem_b [Q_W];
  logic [DEN_W-1:0] dvs_a [Q_W];
  logic [DEN_W-1:0] dvs_b [Q_W];
  logic [Q_W-1:0]   q_a   [Q_W];
  logic [Q_W-1:0]   q_b   [Q_W];
  logic [TAG_W-1:0] tg    [Q_W];
  logic             vld   [Q_W];

  for (genvar i = 0; i < Q_W; i++) begin : g_step
    localparam int BIT = Q_W - 1 - i;
    logic [NUM_W-1:0] ra, rb;
    logic [DEN_W-1:0] da, db;
    logic [Q_W-1:0]   qa, qb;
    logic [TAG_W-1:0] ti;
    logic             vi;
    logic [CMP_W-1:0] sa, sb;
    logic             ge_a, ge_b;

    if (i == 0) begin : g_first
      assign ra = num_a;
      assign rb = num_b;
      assign da = den_a;
      assign db = den_b;
      assign qa = '0;
      assign qb = '0;
      assign ti = tag_in;
      assign vi = in_valid;
    end else begin : g_next
      assign ra = rem_a[i-1];
      assign rb = rem_b[i-1];
      assign da = dvs_a[i-1];
      assign db = dvs_b[i-1];
      assign qa = q_a[i-1];
      assign qb = q_b[i-1];
      assign ti = tg[i-1];
      assign vi = vld[i-1];
    end

    assign sa   = CMP_W'(da) << BIT;
    assign sb   = CMP_W'(db) << BIT;
    assign ge_a = CMP_W'(ra) >= sa;
    assign ge_b = CMP_W'(rb) >= sb;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en) begin
        vld[i] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_a[i] <= ge_a ? NUM_W'(CMP_W'(ra) - sa) : ra;
        rem_b[i] <= ge_b ? NUM_W'(CMP_W'(rb) - sb) : rb;
        dvs_a[i] <= da;
        dvs_b[i] <= db;
        q_a[i]   <= qa | (Q_W'(ge_a) << BIT);
        q_b[i]   <= qb | (Q_W'(ge_b) << BIT);
        tg[i]    <= ti;
      end
    end
  end

  assign out_valid = vld[Q_W-1];
  assign quot_a    = q_a[Q_W-1];
  assign quot_b    = q_b[Q_W-1];
  assign tag_out   = tg[Q_W-1];

endmodule

// ===== rtl/prgp_isqrt.sv =====
// pipelined integer square root, one result bit per stage
// no package dependency; X_W must not exceed 2*RT_W

module prgp_isqrt #(
  parameter int X_W   = 63,
  parameter int RT_W  = 32,
  parameter int TAG_W = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [X_W-1:0]   x,
  input  logic [TAG_W-1:0] tag_in,
  output logic             out_valid,
  output logic [RT_W-1:0]  root,
  output logic [TAG_W-1:0] tag_out
);

  localparam int W = 2 * RT_W + 1;

  logic [W-1:0]     xr  [RT_W];
  logic [W-1:0]     res [RT_W];
  logic [TAG_W-1:0] tg  [RT_W];
  logic             vld [RT_W];

  for (genvar j = 0; j < RT_W; j++) begin : g_step
    localparam int SH = 2 * (RT_W - 1 - j);
    logic [W-1:0]     xi, ri, bitv, trial;
    logic [TAG_W-1:0] ti;
    logic             vi;

    if (j == 0) begin : g_first
      assign xi = W'(x);
      assign ri = '0;
      assign ti = tag_in;
      assign vi = in_valid;
    end else begin : g_next
      assign xi = xr[j-1];
      assign ri = res[j-1];
      assign ti = tg[j-1];
      assign vi = vld[j-1];
    end

    assign bitv  = W'(1) << SH;
    assign trial = ri + bitv;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j] <= 1'b0;
      end else if (en) begin
        vld[j] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (xi >= trial) begin
          xr[j]  <= xi - trial;
          res[j] <= (ri >> 1) + bitv;
        end else begin
          xr[j]  <= xi;
          res[j] <= ri >> 1;
        end
        tg[j] <= ti;
      end
    end
  end

  assign out_valid = vld[RT_W-1];
  assign root      = res[RT_W-1][RT_W-1:0];
  assign tag_out   = tg[RT_W-1];

endmodule

// ===== rtl/prgp_queue.sv =====
// small register queue between the front and back sections
// depends on prgp_pkg for the ray type

module prgp_queue import prgp_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  ray_t din,
  input  logic pop,
  output ray_t head,
  output logic full,
  output logic empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  ray_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] cnt;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        cnt <= cnt + 1'b1;
      end else if (pop && !push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  assign head  = slots[rd_ptr];
  assign full  = cnt == CNT_W'(DEPTH);
  assign empty = cnt == '0;

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue read while empty");
  a_push_fills: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> !empty)
    else $error("queue empty after a lone write");
  a_idle_holds: assert property (@(posedge clk) disable iff (rst)
    (!push && !pop) |=> $stable(cnt))
    else $error("queue count moved without a transfer");

endmodule

// ===== rtl/prgp_front.sv =====
// front section: focal division and rotation of the viewing ray
// depends on prgp_pkg and prgp_div2

module prgp_front import prgp_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  cam_cfg_t                cfg,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [PIX_W-1:0] pix_x,
  input  logic signed [PIX_W-1:0] pix_y,
  input  logic                    full,
  output logic                    push,
  output ray_t                    ray
);

  localparam int PRD_W = ROT_W + NRM_W;
  localparam int CST_W = ROT_W + FRAC_W;

  logic              en;
  logic [PIX_W-1:0]  mag_x, mag_y;
  logic [FOC_W-1:0]  den_x, den_y;
  logic              dv_valid;
  logic [NMAG_W-1:0] qx, qy;
  logic [1:0]        dv_sign;
  logic signed [NRM_W-1:0] nx, ny;
  logic [ROW_W-1:0]  rows [3];

  logic              m1_vld;
  logic signed [CST_W-1:0] p0 [3];
  logic signed [PRD_W-1:0] p1 [3];
  logic signed [PRD_W-1:0] p2 [3];
  logic              m2_vld;
  ray_t              m2_ray;

  assign en       = !m2_vld || !full;
  assign in_ready = en;
  assign push     = m2_vld && !full;
  assign ray      = m2_ray;

  assign mag_x = pix_x[PIX_W-1] ? PIX_W'(-pix_x) : PIX_W'(pix_x);
  assign mag_y = pix_y[PIX_W-1] ? PIX_W'(-pix_y) : PIX_W'(pix_y);
  // a zero focal length divides as one
  assign den_x = (cfg.foc_x == '0) ? FOC_W'(1) : cfg.foc_x;
  assign den_y = (cfg.foc_y == '0) ? FOC_W'(1) : cfg.foc_y;

  prgp_div2 #(
    .NUM_W (NMAG_W),
    .DEN_W (FOC_W),
    .Q_W   (NMAG_W),
    .TAG_W (2)
  ) u_focal_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .num_a     ({mag_x, FRAC_W'(0)}),
    .num_b     ({mag_y, FRAC_W'(0)}),
    .den_a     (den_x),
    .den_b     (den_y),
    .tag_in    ({pix_x[PIX_W-1], pix_y[PIX_W-1]}),
    .out_valid (dv_valid),
    .quot_a    (qx),
    .quot_b    (qy),
    .tag_out   (dv_sign)
  );

  assign nx = dv_sign[1] ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
  assign ny = dv_sign[0] ? -$signed({1'b0, qy}) : $signed({1'b0, qy});

  assign rows[0] = cfg.rot0;
  assign rows[1] = cfg.rot1;
  assign rows[2] = cfg.rot2;

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_vld <= 1'b0;
      m2_vld <= 1'b0;
    end else if (en) begin
      m1_vld <= dv_valid;
      m2_vld <= m1_vld;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_row
    always_ff @(posedge clk) begin
      if (en) begin
        p0[i] <= $signed({rot_elem(rows[i], 0), FRAC_W'(0)});
        p1[i] <= rot_elem(rows[i], 1) * nx;
        p2[i] <= rot_elem(rows[i], 2) * ny;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m2_ray.v0 <= V_W'(p0[0]) + V_W'(p1[0]) + V_W'(p2[0]);
      m2_ray.v1 <= V_W'(p0[1]) + V_W'(p1[1]) + V_W'(p2[1]);
      m2_ray.v2 <= V_W'(p0[2]) + V_W'(p1[2]) + V_W'(p2[2]);
    end
  end

endmodule

// ===== rtl/prgp_back.sv =====
// back section: plane intersection and horizon direction, output register
// depends on prgp_pkg, prgp_div2 and prgp_isqrt

module prgp_back import prgp_pkg::*; #(
  parameter int HORIZON_LENGTH = 10000
) (
  input  logic                    clk,
  input  logic                    rst,
  input  cam_cfg_t                cfg,
  input  ray_t                    head,
  input  logic                    empty,
  output logic                    pop,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [GND_W-1:0] ground_x,
  output logic signed [GND_W-1:0] ground_y,
  output logic                    on_plane
);

  localparam int LO_W  = 23;
  localparam int HI_W  = MAG_W - LO_W;
  localparam int SH_N  = MAG_W - HS_W;
  localparam int SH_W  = $clog2(SH_N + 1);
  localparam int OVC_W = MAG_W + PQ_W + 1;
  localparam int QC_W  = PQ_W + 1;
  localparam int GS_W  = QC_W + 2;
  localparam logic signed [GS_W-1:0] SAT_HI = GS_W'((1 << (GND_W - 1)) - 1);
  localparam logic signed [GS_W-1:0] SAT_LO = -SAT_HI - GS_W'(1);

  typedef struct packed {
    logic              hit;
    logic              s0;
    logic              s1;
    logic              ova;
    logic              ovb;
    logic [SQ_W-1:0]   sumsq;
    logic [HNUM_W-1:0] ta;
    logic [HNUM_W-1:0] tb;
  } ptag_t;

  typedef struct packed {
    logic              hit;
    logic              s0;
    logic              s1;
    logic [GND_W-1:0]  px;
    logic [GND_W-1:0]  py;
    logic [HNUM_W-1:0] ta;
    logic [HNUM_W-1:0] tb;
  } stag_t;

  typedef struct packed {
    logic             hit;
    logic             s0;
    logic             s1;
    logic [GND_W-1:0] px;
    logic [GND_W-1:0] py;
    logic             nz;
  } htag_t;

  function automatic logic signed [GND_W-1:0] sat(input logic signed [GS_W-1:0] v);
    if (v > SAT_HI) return GND_W'(SAT_HI);
    if (v < SAT_LO) return GND_W'(SAT_LO);
    return GND_W'(v);
  endfunction

  logic en;

  // b0: queue head
  logic b0_vld;
  ray_t b0;
  // b1: magnitudes and signs
  logic             b1_vld, b1_hit, b1_s0, b1_s1;
  logic [MAG_W-1:0] b1_a, b1_b, b1_d;
  // b2: partial products and horizon shift
  logic                  b2_vld, b2_hit, b2_s0, b2_s1;
  logic [LO_W+HGT_W-1:0] b2_pa_lo, b2_pb_lo;
  logic [HI_W+HGT_W-1:0] b2_pa_hi, b2_pb_hi;
  logic [HS_W-1:0]       b2_ha, b2_hb;
  logic [MAG_W-1:0]      b2_d;
  logic [MAG_W-1:0]      or_ab;
  logic [SH_W-1:0]       shamt;
  // b3: numerators, squares
  logic              b3_vld, b3_hit, b3_s0, b3_s1;
  logic [PNUM_W-1:0] b3_na, b3_nb;
  logic [2*HS_W-1:0] b3_sqa, b3_sqb;
  logic [HNUM_W-1:0] b3_ta, b3_tb;
  logic [MAG_W-1:0]  b3_d;
  // b4: sum of squares, overflow flags
  logic              b4_vld;
  logic [PNUM_W-1:0] b4_na, b4_nb;
  logic [MAG_W-1:0]  b4_d;
  ptag_t             b4_tag;
  // plane divider out
  logic            pd_vld;
  logic [PQ_W-1:0] pd_qa, pd_qb;
  ptag_t           pd_tag;
  logic [QC_W-1:0] qcx, qcy;
  logic signed [GS_W-1:0] qsx, qsy, gx_raw, gy_raw;
  // b5: plane result
  logic            b5_vld;
  logic [SQ_W-1:0] b5_sumsq;
  stag_t           b5_tag;
  // root out
  logic            rt_vld;
  logic [RT_W-1:0] rt_n;
  stag_t           rt_tag;
  // horizon divider out
  logic            hd_vld;
  logic [HQ_W-1:0] hd_qa, hd_qb;
  htag_t           hd_tag;
  logic signed [GND_W-1:0] hqa, hqb;
  // b6: output register
  logic                    b6_vld;
  logic signed [GND_W-1:0] b6_gx, b6_gy;
  logic                    b6_hit;

  assign en  = !b6_vld || out_ready;
  assign pop = en && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      b0_vld <= 1'b0;
      b1_vld <= 1'b0;
      b2_vld <= 1'b0;
      b3_vld <= 1'b0;
      b4_vld <= 1'b0;
      b5_vld <= 1'b0;
      b6_vld <= 1'b0;
    end else if (en) begin
      b0_vld <= !empty;
      b1_vld <= b0_vld;
      b2_vld <= b1_vld;
      b3_vld <= b2_vld;
      b4_vld <= b3_vld;
      b5_vld <= pd_vld;
      b6_vld <= hd_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b0 <= head;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1_hit <= b0.v2[V_W-1];
      b1_s0  <= b0.v0[V_W-1];
      b1_s1  <= b0.v1[V_W-1];
      b1_a   <= MAG_W'(b0.v0[V_W-1] ? -b0.v0 : b0.v0);
      b1_b   <= MAG_W'(b0.v1[V_W-1] ? -b0.v1 : b0.v1);
      b1_d   <= MAG_W'(b0.v2[V_W-1] ? -b0.v2 : b0.v2);
    end
  end

  // least right shift that brings both magnitudes below 2^31
  assign or_ab = b1_a | b1_b;
  always_comb begin
    shamt = '0;
    for (int k = 0; k < SH_N; k++) begin
      if (or_ab[HS_W+k]) shamt = SH_W'(k + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b2_hit   <= b1_hit;
      b2_s0    <= b1_s0;
      b2_s1    <= b1_s1;
      b2_d     <= b1_d;
      b2_pa_lo <= b1_a[LO_W-1:0] * cfg.height;
      b2_pa_hi <= b1_a[MAG_W-1:LO_W] * cfg.height;
      b2_pb_lo <= b1_b[LO_W-1:0] * cfg.height;
      b2_pb_hi <= b1_b[MAG_W-1:LO_W] * cfg.height;
      b2_ha    <= HS_W'(b1_a >> shamt);
      b2_hb    <= HS_W'(b1_b >> shamt);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b3_hit <= b2_hit;
      b3_s0  <= b2_s0;
      b3_s1  <= b2_s1;
      b3_d   <= b2_d;
      b3_na  <= (PNUM_W'(b2_pa_hi) << LO_W) + PNUM_W'(b2_pa_lo);
      b3_nb  <= (PNUM_W'(b2_pb_hi) << LO_W) + PNUM_W'(b2_pb_lo);
      b3_sqa <= b2_ha * b2_ha;
      b3_sqb <= b2_hb * b2_hb;
      b3_ta  <= b2_ha * HL_W'(HORIZON_LENGTH);
      b3_tb  <= b2_hb * HL_W'(HORIZON_LENGTH);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b4_na        <= b3_na;
      b4_nb        <= b3_nb;
      b4_d         <= b3_d;
      b4_tag.hit   <= b3_hit;
      b4_tag.s0    <= b3_s0;
      b4_tag.s1    <= b3_s1;
      b4_tag.ova   <= OVC_W'(b3_na) >= (OVC_W'(b3_d) << PQ_W);
      b4_tag.ovb   <= OVC_W'(b3_nb) >= (OVC_W'(b3_d) << PQ_W);
      b4_tag.sumsq <= SQ_W'(b3_sqa) + SQ_W'(b3_sqb);
      b4_tag.ta    <= b3_ta;
      b4_tag.tb    <= b3_tb;
    end
  end

  prgp_div2 #(
    .NUM_W (PNUM_W),
    .DEN_W (MAG_W),
    .Q_W   (PQ_W),
    .TAG_W ($bits(ptag_t))
  ) u_plane_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (b4_vld),
    .num_a     (b4_na),
    .num_b     (b4_nb),
    .den_a     (b4_d),
    .den_b     (b4_d),
    .tag_in    (b4_tag),
    .out_valid (pd_vld),
    .quot_a    (pd_qa),
    .quot_b    (pd_qb),
    .tag_out   (pd_tag)
  );

  // quotients too large for 18 bits are clamped before the offset
  assign qcx    = pd_tag.ova ? QC_W'(1) << PQ_W : QC_W'(pd_qa);
  assign qcy    = pd_tag.ovb ? QC_W'(1) << PQ_W : QC_W'(pd_qb);
  assign qsx    = $signed(GS_W'(qcx));
  assign qsy    = $signed(GS_W'(qcy));
  assign gx_raw = (pd_tag.s0 ? -qsx : qsx) + GS_W'(cfg.ofs_x);
  assign gy_raw = (pd_tag.s1 ? qsy : -qsy) - GS_W'(cfg.ofs_y);

  always_ff @(posedge clk) begin
    if (en) begin
      b5_sumsq   <= pd_tag.sumsq;
      b5_tag.hit <= pd_tag.hit;
      b5_tag.s0  <= pd_tag.s0;
      b5_tag.s1  <= pd_tag.s1;
      b5_tag.px  <= sat(gx_raw);
      b5_tag.py  <= sat(gy_raw);
      b5_tag.ta  <= pd_tag.ta;
      b5_tag.tb  <= pd_tag.tb;
    end
  end

  prgp_isqrt #(
    .X_W   (SQ_W),
    .RT_W  (RT_W),
    .TAG_W ($bits(stag_t))
  ) u_root (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (b5_vld),
    .x         (b5_sumsq),
    .tag_in    (b5_tag),
    .out_valid (rt_vld),
    .root      (rt_n),
    .tag_out   (rt_tag)
  );

  prgp_div2 #(
    .NUM_W (HNUM_W),
    .DEN_W (RT_W),
    .Q_W   (HQ_W),
    .TAG_W ($bits(htag_t))
  ) u_horizon_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (rt_vld),
    .num_a     (rt_tag.ta),
    .num_b     (rt_tag.tb),
    .den_a     (rt_n),
    .den_b     (rt_n),
    .tag_in    ({rt_tag.hit, rt_tag.s0, rt_tag.s1, rt_tag.px, rt_tag.py, rt_n == '0}),
    .out_valid (hd_vld),
    .quot_a    (hd_qa),
    .quot_b    (hd_qb),
    .tag_out   (hd_tag)
  );

  assign hqa = $signed(GND_W'(hd_qa));
  assign hqb = $signed(GND_W'(hd_qb));

  always_ff @(posedge clk) begin
    if (en) begin
      b6_hit <= hd_tag.hit;
      if (hd_tag.hit) begin
        b6_gx <= $signed(hd_tag.px);
        b6_gy <= $signed(hd_tag.py);
      end else if (hd_tag.nz) begin
        // no horizontal direction at all
        b6_gx <= $signed(GND_W'(HORIZON_LENGTH));
        b6_gy <= '0;
      end else begin
        b6_gx <= hd_tag.s0 ? -hqa : hqa;
        b6_gy <= hd_tag.s1 ? -hqb : hqb;
      end
    end
  end

  assign out_valid = b6_vld;
  assign ground_x  = b6_gx;
  assign ground_y  = b6_gy;
  assign on_plane  = b6_hit;

endmodule

// ===== rtl/pixel_ray_ground_projection.sv =====
// top level of the pixel ray to ground plane projection block
// depends on prgp_pkg, prgp_if, prgp_front, prgp_queue and prgp_back
//
//  port        dir  kind             carries
//  ----------  ---  ---------------  ---------------------------------------
//  pix_in      in   valid/ready      pix_x, pix_y (signed pixel coordinate)
//  gnd_out     out  valid/ready      ground_x, ground_y, on_plane
//  cfg_*       in   write only       cfg_we, cfg_addr (0..7), cfg_wdata
//
// one transfer per cycle in steady state while the output is taken; the
// front has 28 focal division steps plus two matrix stages and the back has
// 18 plane division steps, 32 root steps, 15 horizon division steps and glue
// synchronous reset clears all valid flags and loads the default registers
// the front stalls only when the queue is full, the back only when the
// output register holds an untaken result

module pixel_ray_ground_projection import prgp_pkg::*; #(
  parameter int HORIZON_LENGTH = 10000,
  parameter int QUEUE_DEPTH    = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  prgp_pix_if.sink              pix_in,
  prgp_gnd_if.source            gnd_out
);

  // identity rotation in Q1.14 after reset
  localparam logic [ROW_W-1:0] ROT_ROW0_RST = 48'd16384;
  localparam logic [ROW_W-1:0] ROT_ROW1_RST = 48'd1073741824;
  localparam logic [ROW_W-1:0] ROT_ROW2_RST = 48'd70368744177664;
  localparam logic [FOC_W-1:0] FOCAL_RST    = 12'd320;
  localparam logic [HGT_W-1:0] HEIGHT_RST   = 16'd510;

  cam_cfg_t cfg;
  ray_t     fr_ray, q_head;
  logic     q_push, q_pop, q_full, q_empty;

  // configuration registers; the user must write them only while the block is idle, the block does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rot0   <= ROT_ROW0_RST;
      cfg.rot1   <= ROT_ROW1_RST;
      cfg.rot2   <= ROT_ROW2_RST;
      cfg.foc_x  <= FOCAL_RST;
      cfg.foc_y  <= FOCAL_RST;
      cfg.ofs_x  <= '0;
      cfg.ofs_y  <= '0;
      cfg.height <= HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_ROT_ROW0: cfg.rot0   <= cfg_wdata[ROW_W-1:0];
        REG_ROT_ROW1: cfg.rot1   <= cfg_wdata[ROW_W-1:0];
        REG_ROT_ROW2: cfg.rot2   <= cfg_wdata[ROW_W-1:0];
        REG_FOCAL_X:  cfg.foc_x  <= cfg_wdata[FOC_W-1:0];
        REG_FOCAL_Y:  cfg.foc_y  <= cfg_wdata[FOC_W-1:0];
        REG_OFFSET_X: cfg.ofs_x  <= $signed(cfg_wdata[OFS_W-1:0]);
        REG_OFFSET_Y: cfg.ofs_y  <= $signed(cfg_wdata[OFS_W-1:0]);
        REG_HEIGHT:   cfg.height <= cfg_wdata[HGT_W-1:0];
        default: ;
      endcase
    end
  end

  // front: normalize by focal length, rotate into the ray
  prgp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (pix_in.valid),
    .in_ready (pix_in.ready),
    .pix_x    (pix_in.pix_x),
    .pix_y    (pix_in.pix_y),
    .full     (q_full),
    .push     (q_push),
    .ray      (fr_ray)
  );

  // decouples the two sections so each stalls on its own
  prgp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (fr_ray),
    .pop   (q_pop),
    .head  (q_head),
    .full  (q_full),
    .empty (q_empty)
  );

  // back: intersect with the plane or fall back to the horizon direction
  prgp_back #(
    .HORIZON_LENGTH (HORIZON_LENGTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .head      (q_head),
    .empty     (q_empty),
    .pop       (q_pop),
    .out_valid (gnd_out.valid),
    .out_ready (gnd_out.ready),
    .ground_x  (gnd_out.ground_x),
    .ground_y  (gnd_out.ground_y),
    .on_plane  (gnd_out.on_plane)
  );

endmodule
